[hw/rtl/edge_element_quad_local_matrix_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quad edge-element matrix block
// Implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EDGE_ELEMENT_QUAD_LOCAL_MATRIX_ASSERT_SVH
`define EDGE_ELEMENT_QUAD_LOCAL_MATRIX_ASSERT_SVH

// same-cycle implication
`define EEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/eeq_pkg.sv]
// ----------------------------------------------------------------------------
// eeq_pkg
// Types, constants and helpers shared by the quad edge-element matrix block.
// ----------------------------------------------------------------------------
package eeq_pkg;

  localparam int EEQ_ORDER  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int Q_W        = 32;
  localparam int PROD_W     = 64;
  localparam int MAG_W      = 63;
  localparam int TERM_W     = 48;
  localparam int MSUM_W     = 49;
  localparam int DSUM_W     = 50;
  localparam int TOT_W      = 51;
  localparam int NUM_SHIFT  = 14;
  localparam int WDET_SHIFT = 46;
  localparam int DIV_STEPS  = 32;

  localparam logic [3:0] SLOT_LAST = 4'd15;
  localparam logic signed [31:0] GAIN_RESET = 32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS_GAIN = 2'd0,
    CFG_CURL_GAIN = 2'd1
  } eeq_cfg_idx_t;

  // geometric factor computed by one division slot
  typedef enum logic [1:0] {
    FAC_F11  = 2'd0,
    FAC_F12  = 2'd1,
    FAC_F22  = 2'd2,
    FAC_WDET = 2'd3
  } eeq_fac_t;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;
    logic [1:0]         cell_col;
    logic [1:0]         cell_row;
  } eeq_in_t;

  typedef struct packed {
    logic [4:0]         row_dof;
    logic               component;
    logic [2:0]         column_slot;
    logic signed [31:0] entry_value;
    logic               degenerate;
    logic               last;
  } eeq_out_t;

  typedef struct packed {
    logic [1:0] corner;
    eeq_fac_t   fac;
    logic [1:0] kx;
    logic [1:0] ky;
  } eeq_tag_t;

  typedef struct packed {
    eeq_tag_t           tag;
    logic [MAG_W-1:0]   un;
    logic [MAG_W-1:0]   ud;
    logic               wdet;
    logic               neg;
    logic               zero;
  } eeq_div_req_t;

  typedef struct packed {
    eeq_tag_t           tag;
    logic signed [31:0] factor;
    logic               zero;
  } eeq_div_rsp_t;

  // corner difference clamped to the symmetric Q16.16 range
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > 33'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (d < -33'sd2147483647) begin
      return 32'sh8000_0001;
    end
    return d[31:0];
  endfunction

endpackage

[hw/rtl/eeq_div.sv]
// ----------------------------------------------------------------------------
// eeq_div
// Pipelined restoring divider: magnitude quotient of num*2^s / den, one
// quotient bit per stage, truncated and saturated to signed Q16.16.
// ----------------------------------------------------------------------------
module eeq_div import eeq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  input  eeq_div_req_t req,
  output logic         rsp_valid,
  output eeq_div_rsp_t rsp
);

  localparam int N_W  = MAG_W + NUM_SHIFT;
  localparam int HI_W = N_W - DIV_STEPS;

  typedef struct packed {
    eeq_tag_t              tag;
    logic [MAG_W-1:0]      r;
    logic [MAG_W-1:0]      ud;
    logic [DIV_STEPS-1:0]  lo;
    logic [DIV_STEPS-1:0]  q;
    logic                  sat;
    logic                  neg;
    logic                  zero;
  } eeq_dstage_t;

  eeq_dstage_t st_r [0:DIV_STEPS];
  logic        sv_r [0:DIV_STEPS];

  logic [N_W-1:0]  n_full;
  logic [HI_W-1:0] n_hi;

  assign n_full = req.wdet ? (N_W'(1) << WDET_SHIFT) : {req.un, NUM_SHIFT'(0)};
  assign n_hi   = n_full[N_W-1:DIV_STEPS];

  // head stage: quotient bits above bit 31 exist iff the high part reaches den
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0].tag  <= req.tag;
    st_r[0].r    <= MAG_W'(n_hi);
    st_r[0].ud   <= req.ud;
    st_r[0].lo   <= n_full[DIV_STEPS-1:0];
    st_r[0].q    <= '0;
    st_r[0].sat  <= (MAG_W'(n_hi) >= req.ud);
    st_r[0].neg  <= req.neg;
    st_r[0].zero <= req.zero;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MAG_W:0] r2;
    logic           ge;
    eeq_dstage_t    st_nxt;

    always_comb begin
      r2        = {st_r[k].r, st_r[k].lo[DIV_STEPS-1]};
      ge        = (r2 >= {1'b0, st_r[k].ud});
      st_nxt    = st_r[k];
      st_nxt.r  = ge ? MAG_W'(r2 - {1'b0, st_r[k].ud}) : r2[MAG_W-1:0];
      st_nxt.q  = {st_r[k].q[DIV_STEPS-2:0], ge};
      st_nxt.lo = st_r[k].lo << 1;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      st_r[k+1] <= st_nxt;
    end
  end

  logic        [32:0] lim;
  logic        [32:0] qq;
  logic        [32:0] mag;
  logic signed [32:0] val;

  always_comb begin
    lim = st_r[DIV_STEPS].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    qq  = {1'b0, st_r[DIV_STEPS].q};
    mag = (st_r[DIV_STEPS].sat || (qq > lim)) ? lim : qq;
    val = st_r[DIV_STEPS].neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= sv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    rsp.tag    <= st_r[DIV_STEPS].tag;
    rsp.zero   <= st_r[DIV_STEPS].zero;
    rsp.factor <= st_r[DIV_STEPS].zero ? 32'sd0 : val[31:0];
  end

endmodule

[hw/rtl/edge_element_quad_local_matrix.sv]
// ----------------------------------------------------------------------------
// edge_element_quad_local_matrix
// 4x4 lowest-order edge-element mass plus curl-curl matrix of one quad cell.
// ----------------------------------------------------------------------------
// A new cell is taken only once the previous one has issued all its divisions:
// each cell needs 16 divisions (four factors at each of four corners), issued
// one per cycle into a single pipelined divider, and busy stays high until the
// last of them is being issued. The 16 entries of a cell come out as one
// unbroken burst of 16 strobes, row-major. Results cannot be held off and never
// need to be: bursts of successive cells never overlap.
// cfg_ready is always high; gains may change only while the block is idle.
`include "edge_element_quad_local_matrix_assert.svh"

module edge_element_quad_local_matrix import eeq_pkg::*; #(
  parameter int ORDER = EEQ_ORDER
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  eeq_in_t              in_data,
  output logic                 out_valid,
  output eeq_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int KMAX = ORDER - 1;

  // ---------------- configuration
  logic signed [31:0] mass_gain_r;
  logic signed [31:0] curl_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_gain_r <= GAIN_RESET;
      curl_gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASS_GAIN: mass_gain_r <= cfg_data;
        CFG_CURL_GAIN: curl_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- slot issue: one division slot per cycle
  logic    accept;
  logic    act_r;
  logic [3:0] cnt_r;
  eeq_in_t item_r;

  assign busy   = act_r && (cnt_r != SLOT_LAST);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (accept) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      if (cnt_r == SLOT_LAST) begin
        act_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  eeq_tag_t           tag0;
  logic               iqx;
  logic               iqy;
  logic signed [31:0] j11_c, j12_c, j21_c, j22_c;

  always_comb begin
    tag0.corner = cnt_r[3:2];
    tag0.fac    = eeq_fac_t'(cnt_r[1:0]);
    tag0.kx     = (int'(item_r.cell_col) > KMAX) ? 2'(KMAX) : item_r.cell_col;
    tag0.ky     = (int'(item_r.cell_row) > KMAX) ? 2'(KMAX) : item_r.cell_row;
    iqx   = cnt_r[3];
    iqy   = cnt_r[2];
    j11_c = iqy ? sat_diff(item_r.corner2_x, item_r.corner3_x)
                : sat_diff(item_r.corner1_x, item_r.corner0_x);
    j12_c = iqx ? sat_diff(item_r.corner2_x, item_r.corner1_x)
                : sat_diff(item_r.corner3_x, item_r.corner0_x);
    j21_c = iqy ? sat_diff(item_r.corner2_y, item_r.corner3_y)
                : sat_diff(item_r.corner1_y, item_r.corner0_y);
    j22_c = iqx ? sat_diff(item_r.corner2_y, item_r.corner1_y)
                : sat_diff(item_r.corner3_y, item_r.corner0_y);
  end

  // ---------------- S1: Jacobian of the slot's corner
  logic               v1_r;
  eeq_tag_t           tag1_r;
  logic signed [31:0] j11_r, j12_r, j21_r, j22_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= tag0;
    j11_r  <= j11_c;
    j12_r  <= j12_c;
    j21_r  <= j21_c;
    j22_r  <= j22_c;
  end

  // ---------------- S2: products for det and the factor's numerator
  logic signed [31:0]       ca0, ca1, cb0, cb1;
  logic                     v2_r;
  eeq_tag_t                 tag2_r;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;

  always_comb begin
    ca0 = (tag1_r.fac == FAC_F22) ? j11_r : j12_r;
    ca1 = (tag1_r.fac == FAC_F11) ? j12_r : j11_r;
    cb0 = (tag1_r.fac == FAC_F22) ? j21_r : j22_r;
    cb1 = (tag1_r.fac == FAC_F11) ? j22_r : j21_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    tag2_r <= tag1_r;
    pa_r   <= j11_r * j22_r;
    pb_r   <= j21_r * j12_r;
    pc_r   <= ca0 * ca1;
    pd_r   <= cb0 * cb1;
  end

  // ---------------- S3: determinant and numerator
  logic                     v3_r;
  eeq_tag_t                 tag3_r;
  logic signed [PROD_W-1:0] den_r, num_r;
  logic signed [PROD_W-1:0] num_c;

  always_comb begin
    case (tag2_r.fac)
      FAC_F11, FAC_F22: num_c = pc_r + pd_r;
      FAC_F12:          num_c = -(pc_r + pd_r);
      default:          num_c = 64'sd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag3_r <= tag2_r;
    den_r  <= pa_r - pb_r;
    num_r  <= num_c;
  end

  // ---------------- S4: signs and magnitudes for the divider
  logic                     v4_r;
  eeq_div_req_t             req_r;
  logic signed [PROD_W-1:0] num_abs, den_abs;

  always_comb begin
    num_abs = num_r[PROD_W-1] ? -num_r : num_r;
    den_abs = den_r[PROD_W-1] ? -den_r : den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    req_r.tag  <= tag3_r;
    req_r.un   <= num_abs[MAG_W-1:0];
    req_r.ud   <= den_abs[MAG_W-1:0];
    req_r.wdet <= (tag3_r.fac == FAC_WDET);
    req_r.neg  <= num_r[PROD_W-1] ^ den_r[PROD_W-1];
    req_r.zero <= (den_r == '0);
  end

  logic         rsp_valid;
  eeq_div_rsp_t rsp;

  eeq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (v4_r),
    .req       (req_r),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // ---------------- M: gain times factor, floor to Q32.16
  logic                     vm_r;
  eeq_tag_t                 tagm_r;
  logic                     zm_r;
  logic signed [TERM_W-1:0] term_r;
  logic signed [31:0]       gain_c;
  logic signed [PROD_W-1:0] gp_c;

  assign gain_c = (rsp.tag.fac == FAC_WDET) ? curl_gain_r : mass_gain_r;
  assign gp_c   = gain_c * rsp.factor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    tagm_r <= rsp.tag;
    zm_r   <= rsp.zero;
    term_r <= gp_c[PROD_W-1:16];
  end

  // ---------------- collector and output bank
  logic signed [TERM_W-1:0] ca_r [0:3];
  logic signed [TERM_W-1:0] cb_r [0:3];
  logic signed [TERM_W-1:0] cc_r [0:3];
  logic signed [DSUM_W-1:0] dsum_r;
  logic                     deg_r;

  logic signed [TERM_W-1:0] oa_r [0:3];
  logic signed [TERM_W-1:0] ob_r [0:3];
  logic signed [TERM_W-1:0] oc_r [0:3];
  logic signed [DSUM_W-1:0] od_r;
  logic                     odeg_r;
  logic [1:0]               okx_r, oky_r;

  logic oact_r;
  logic [3:0] ocnt_r;
  logic cl_last;
  logic cl_first;

  assign cl_last  = vm_r && (tagm_r.corner == 2'd3) && (tagm_r.fac == FAC_WDET);
  assign cl_first = (tagm_r.corner == 2'd0) && (tagm_r.fac == FAC_F11);

  always_ff @(posedge clk) begin
    if (vm_r) begin
      case (tagm_r.fac)
        FAC_F11: ca_r[tagm_r.corner] <= term_r;
        FAC_F12: cb_r[tagm_r.corner] <= term_r;
        FAC_F22: cc_r[tagm_r.corner] <= term_r;
        default: begin
          dsum_r <= (tagm_r.corner == 2'd0) ? DSUM_W'(term_r)
                                            : dsum_r + DSUM_W'(term_r);
        end
      endcase
      deg_r <= cl_first ? zm_r : (deg_r | zm_r);
    end
    if (cl_last) begin
      oa_r   <= ca_r;
      ob_r   <= cb_r;
      oc_r   <= cc_r;
      od_r   <= dsum_r + DSUM_W'(term_r);
      odeg_r <= deg_r | zm_r;
      okx_r  <= tagm_r.kx;
      oky_r  <= tagm_r.ky;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oact_r <= 1'b0;
      ocnt_r <= '0;
    end else if (cl_last) begin
      oact_r <= 1'b1;
      ocnt_r <= '0;
    end else if (oact_r) begin
      if (ocnt_r == SLOT_LAST) begin
        oact_r <= 1'b0;
      end else begin
        ocnt_r <= ocnt_r + 4'd1;
      end
    end
  end

  // ---------------- O1: pick the mass terms, curl sign and indices of entry (i, j)
  logic signed [TERM_W-1:0] op_a, op_b;
  logic                     ci, bi, cj, bj;
  logic                     o1v_r;
  logic signed [MSUM_W-1:0] ms_r;
  logic signed [DSUM_W-1:0] dt_r;
  eeq_out_t                 o1_r;
  eeq_out_t                 o1_c;

  always_comb begin
    ci   = ocnt_r[3];
    bi   = ocnt_r[2];
    cj   = ocnt_r[1];
    bj   = ocnt_r[0];
    op_a = '0;
    op_b = '0;
    case (ocnt_r)
      4'd0:  begin op_a = oa_r[0]; op_b = oa_r[2]; end
      4'd2:  op_a = ob_r[0];
      4'd3:  op_a = ob_r[2];
      4'd5:  begin op_a = oa_r[1]; op_b = oa_r[3]; end
      4'd6:  op_a = ob_r[1];
      4'd7:  op_a = ob_r[3];
      4'd8:  op_a = ob_r[0];
      4'd9:  op_a = ob_r[1];
      4'd10: begin op_a = oc_r[0]; op_b = oc_r[1]; end
      4'd12: op_a = ob_r[2];
      4'd13: op_a = ob_r[3];
      4'd15: begin op_a = oc_r[2]; op_b = oc_r[3]; end
      default: ;
    endcase
    o1_c.row_dof = ci ? 5'(int'(okx_r) + int'(bi) + int'(oky_r) * (ORDER + 1))
                      : 5'(int'(okx_r) + (int'(oky_r) + int'(bi)) * ORDER);
    o1_c.component   = ci;
    o1_c.column_slot = (ci == cj) ? 3'(int'(bj) - int'(bi) + 1)
                                  : 3'(3 + int'(bj) + (1 - int'(bi)) * 2);
    o1_c.entry_value = '0;
    o1_c.degenerate  = odeg_r;
    o1_c.last        = (ocnt_r == SLOT_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1v_r <= 1'b0;
    end else begin
      o1v_r <= oact_r;
    end
  end

  always_ff @(posedge clk) begin
    o1_r <= o1_c;
    ms_r <= MSUM_W'(op_a) + MSUM_W'(op_b);
    // curl part sign is the product of the row and column edge signs
    dt_r <= (ci ^ bi ^ cj ^ bj) ? -od_r : od_r;
  end

  // ---------------- O2: total and saturation
  logic signed [TOT_W-1:0] tot;
  logic signed [31:0]      val_c;
  eeq_out_t                out_c;
  eeq_out_t                out_r;
  logic                    ov_r;

  always_comb begin
    tot = TOT_W'(ms_r) + TOT_W'(dt_r);
    if (tot > TOT_W'(64'sh7FFF_FFFF)) begin
      val_c = 32'sh7FFF_FFFF;
    end else if (tot < TOT_W'(-64'sh8000_0000)) begin
      val_c = 32'sh8000_0000;
    end else begin
      val_c = tot[31:0];
    end
    out_c             = o1_r;
    out_c.entry_value = val_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= o1v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_c;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  // ---------------- checks
  `EEQ_ASSERT_NXT(a_accept_busy, accept, busy, "busy low right after an accepted item")
  `EEQ_ASSERT_NXT(a_burst_whole, out_valid && !out_data.last, out_valid, "entry burst broken")
  `EEQ_ASSERT_IMP(a_bank_free, cl_last, !oact_r || (ocnt_r == SLOT_LAST), "bank reload in burst")

endmodule

[sim/edge_element_quad_local_matrix_tb.sv]
// ----------------------------------------------------------------------------
// edge_element_quad_local_matrix_tb
// Quad cells go in through start/busy in bursts with random gaps. Each accepted
// cell is predicted in Q16.16 here, and the 16 strobed entries are checked in
// order. Gains are rewritten between phases, with the block drained each time.
// ----------------------------------------------------------------------------
module edge_element_quad_local_matrix_tb;
  import eeq_pkg::*;

  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  eeq_in_t in_data = '0;
  logic out_valid;
  eeq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  eeq_in_t cell_q[$];
  eeq_out_t entry_q[$];
  longint mass_k = 65536;
  longint curl_k = 65536;
  int errors = 0;
  int cells_done = 0;
  int entries_seen = 0;
  int degen_cells = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic accepted;

  edge_element_quad_local_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_sym(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  // trunc(num * 2^sh / den) saturated to Q16.16
  function automatic longint fdiv(longint num, int sh, longint den);
    logic neg;
    logic [127:0] un, ud, q, lim;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? 128'(-num) : 128'(num);
    ud = (den < 0) ? 128'(-den) : 128'(den);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    q = (un << sh) / ud;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint qmul_floor(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  task automatic predict_cell(input eeq_in_t c);
    longint vx[4], vy[4];
    longint f[2][2][4];
    longint j11, j12, j21, j22, det, acc, m;
    logic deg;
    int kx, ky, ci, bi, cj, bj, si, sj, ix, iy;
    eeq_out_t e;
    vx[0] = c.corner0_x; vy[0] = c.corner0_y;
    vx[1] = c.corner1_x; vy[1] = c.corner1_y;
    vx[2] = c.corner2_x; vy[2] = c.corner2_y;
    vx[3] = c.corner3_x; vy[3] = c.corner3_y;
    kx = (c.cell_col > EEQ_ORDER - 1) ? EEQ_ORDER - 1 : c.cell_col;
    ky = (c.cell_row > EEQ_ORDER - 1) ? EEQ_ORDER - 1 : c.cell_row;
    deg = 1'b0;
    for (int qx = 0; qx < 2; qx++) begin
      for (int qy = 0; qy < 2; qy++) begin
        j11 = clamp_sym(qy ? vx[2] - vx[3] : vx[1] - vx[0]);
        j12 = clamp_sym(qx ? vx[2] - vx[1] : vx[3] - vx[0]);
        j21 = clamp_sym(qy ? vy[2] - vy[3] : vy[1] - vy[0]);
        j22 = clamp_sym(qx ? vy[2] - vy[1] : vy[3] - vy[0]);
        det = j11 * j22 - j21 * j12;
        if (det == 0) begin
          deg = 1'b1;
          for (int k = 0; k < 4; k++) f[qx][qy][k] = 0;
        end else begin
          f[qx][qy][0] = fdiv(j12 * j12 + j22 * j22, NUM_SHIFT, det);
          f[qx][qy][1] = fdiv(-(j12 * j11 + j22 * j21), NUM_SHIFT, det);
          f[qx][qy][2] = fdiv(j11 * j11 + j21 * j21, NUM_SHIFT, det);
          f[qx][qy][3] = fdiv(1, WDET_SHIFT, det);
        end
      end
    end
    if (deg) degen_cells++;
    for (int i = 0; i < 4; i++) begin
      ci = i >> 1; bi = i & 1;
      ix = (ci == 0) ? 0 : bi;
      iy = (ci == 1) ? 0 : bi;
      si = ((ci == 0) ? 1 : -1) * ((bi == 0) ? 1 : -1);
      for (int j = 0; j < 4; j++) begin
        cj = j >> 1; bj = j & 1;
        sj = ((cj == 0) ? 1 : -1) * ((bj == 0) ? 1 : -1);
        acc = 0;
        for (int qx = 0; qx < 2; qx++) begin
          for (int qy = 0; qy < 2; qy++) begin
            m = 0;
            if (ci == 0 && cj == 0) begin
              if (bi == qy && bj == qy) m = f[qx][qy][0];
            end else if (ci == 1 && cj == 1) begin
              if (bi == qx && bj == qx) m = f[qx][qy][2];
            end else if (ci == 0) begin
              if (bi == qy && bj == qx) m = f[qx][qy][1];
            end else begin
              if (bi == qx && bj == qy) m = f[qx][qy][1];
            end
            acc += qmul_floor(mass_k, m);
            acc += longint'(si * sj) * qmul_floor(curl_k, f[qx][qy][3]);
          end
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        e.row_dof = (ci == 0) ? 5'(kx + ix + (ky + iy) * EEQ_ORDER)
                              : 5'(kx + ix + (ky + iy) * (EEQ_ORDER + 1));
        e.component = ci[0];
        e.column_slot = (ci == cj) ? 3'(bj - bi + 1) : 3'(3 + bj + (1 - bi) * 2);
        e.entry_value = acc[31:0];
        e.degenerate = deg;
        e.last = (i == 3 && j == 3);
        entry_q.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH entry %0d: %s got %0d expected %0d", entries_seen, what, got, want);
    errors++;
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        predict_cell(in_data);
        cells_done++;
      end
      if (start && !accepted) begin
        // hold the item until busy drops
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cell_q.size() > 0) begin
        in_data <= cell_q.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (entry_q.size() == 0) begin
        report_mismatch("entry with nothing expected", out_data.entry_value, 0);
      end else begin
        eeq_out_t w;
        w = entry_q.pop_front();
        if (out_data.row_dof !== w.row_dof)
          report_mismatch("row_dof", out_data.row_dof, w.row_dof);
        if (out_data.component !== w.component)
          report_mismatch("component", out_data.component, w.component);
        if (out_data.column_slot !== w.column_slot)
          report_mismatch("column_slot", out_data.column_slot, w.column_slot);
        if (out_data.entry_value !== w.entry_value)
          report_mismatch("entry_value", out_data.entry_value, w.entry_value);
        if (out_data.degenerate !== w.degenerate)
          report_mismatch("degenerate", out_data.degenerate, w.degenerate);
        if (out_data.last !== w.last)
          report_mismatch("last", out_data.last, w.last);
      end
      entries_seen++;
    end
  end

  function automatic eeq_in_t make_cell(longint x0, longint y0, longint x1, longint y1,
                                        longint x2, longint y2, longint x3, longint y3,
                                        int col, int row);
    eeq_in_t c;
    c.corner0_x = x0[31:0]; c.corner0_y = y0[31:0];
    c.corner1_x = x1[31:0]; c.corner1_y = y1[31:0];
    c.corner2_x = x2[31:0]; c.corner2_y = y2[31:0];
    c.corner3_x = x3[31:0]; c.corner3_y = y3[31:0];
    c.cell_col = col[1:0]; c.cell_row = row[1:0];
    return c;
  endfunction

  function automatic int jit(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // mostly well-shaped quads, some raw noise and some collapsed corners
  function automatic eeq_in_t rand_cell();
    eeq_in_t c;
    int bx, by, h, sel, jj;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 4'($urandom)};
      return c;
    end
    bx = jit(1 << 22); by = jit(1 << 22);
    h = $urandom_range(1, (sel < 6) ? 64 : (1 << 20));
    jj = h / 3;
    c = make_cell(bx + jit(jj), by + jit(jj), bx + h + jit(jj), by + jit(jj),
                  bx + h + jit(jj), by + h + jit(jj), bx + jit(jj), by + h + jit(jj),
                  $urandom_range(0, 3), $urandom_range(0, 3));
    if (sel == 19) begin
      c.corner2_x = c.corner1_x;
      c.corner2_y = c.corner1_y;
    end
    return c;
  endfunction

  task automatic write_reg(input eeq_cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MASS_GAIN) mass_k = longint'(signed'(val));
    else curl_k = longint'(signed'(val));
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (cell_q.size() > 0 || start || entry_q.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed cells at reset gains
    cell_q.push_back(make_cell(0, 0, 65536, 0, 65536, 65536, 0, 65536, 0, 0));
    cell_q.push_back(make_cell(0, 0, 65536, 0, 65536, 65536, 0, 65536, 3, 3));
    cell_q.push_back(make_cell(0, 0, 65536, 0, 65536, 65536, 0, 65536, 3, 0));
    cell_q.push_back(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 1, 2));
    cell_q.push_back(make_cell(mn, mn, mx, mn, mx, mx, mn, mx, 2, 1));
    cell_q.push_back(make_cell(mx, mx, mn, mx, mn, mn, mx, mn, 0, 3));
    cell_q.push_back(make_cell(0, 0, 1, 0, 1, 1, 0, 1, 1, 1));
    cell_q.push_back(make_cell(0, 0, 65536, 0, 65536, 0, 0, 65536, 2, 2));
    cell_q.push_back(make_cell(0, 0, 0, 65536, 65536, 65536, 65536, 0, 0, 1));
    cell_q.push_back(make_cell(-65536, -65536, 1 << 30, 0, 1 << 30, 1 << 30, 0, 1 << 30,
                               1, 0));
    cell_q.push_back(make_cell(0, 0, 1 << 28, 1 << 27, 1 << 29, 1 << 29, -(1 << 20),
                               1 << 28, 3, 2));
    cell_q.push_back(make_cell(-1, -1, -1, -1, -1, -1, -1, -1, 3, 3));
    for (int k = 0; k < 30; k++) cell_q.push_back(rand_cell());
    wait_drained();

    // gain extremes
    write_reg(CFG_MASS_GAIN, 32'h7FFF_FFFF);
    write_reg(CFG_CURL_GAIN, 32'h8000_0000);
    cell_q.push_back(make_cell(0, 0, 1, 0, 1, 1, 0, 1, 0, 0));
    cell_q.push_back(make_cell(0, 0, 65536, 0, 65536, 65536, 0, 65536, 2, 3));
    cell_q.push_back(make_cell(mn, mn, mx, mn, mx, mx, mn, mx, 1, 1));
    for (int k = 0; k < 45; k++) cell_q.push_back(rand_cell());
    wait_drained();

    write_reg(CFG_MASS_GAIN, 32'h8000_0000);
    write_reg(CFG_CURL_GAIN, 32'h7FFF_FFFF);
    cell_q.push_back(make_cell(0, 0, 1, 0, 1, 1, 0, 1, 3, 1));
    for (int k = 0; k < 45; k++) cell_q.push_back(rand_cell());
    wait_drained();

    write_reg(CFG_MASS_GAIN, 32'h0);
    write_reg(CFG_CURL_GAIN, 32'hFFFF_0000);
    for (int k = 0; k < 40; k++) cell_q.push_back(rand_cell());
    wait_drained();

    write_reg(CFG_MASS_GAIN, $urandom);
    write_reg(CFG_CURL_GAIN, $urandom_range(0, 1 << 20));
    for (int k = 0; k < 40; k++) cell_q.push_back(rand_cell());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d cells (%0d degenerate) and %0d entries over five gain settings,",
             cells_done, degen_cells, entries_seen);
    $display("including saturated corners, collapsed corners and every cell position.");
    if (errors == 0 && entry_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
